/* hw/rtl/gni_pkg.sv */
// shared types and constants of the grid neighbor index generator
package gni_pkg;

    localparam int AXES     = 3;
    localparam int MAX_AXES = 3;
    localparam int SIDE_DEF = 256;
    localparam int SIZE_W   = 9;
    localparam int CNT_W    = 2;
    localparam int MASK_W   = 3;
    localparam int IDX_W    = 24;
    localparam int NB_W     = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 176;
    localparam int SETTLE_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_AXIS2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC   = 3'd4;

    typedef struct packed {
        logic [AXES-1:0]             used;
        logic [AXES-1:0]             periodic;
        logic [AXES-1:0][SIZE_W-1:0] size;
        logic [AXES-1:0][IDX_W-1:0]  stride;
        logic [AXES-1:0][NB_W-1:0]   wrap;
        logic                        busy;
        logic                        clear;
    } geom_t;

endpackage

/* hw/rtl/gni_cfg.sv */
// configuration registers, axis strides and wrap offsets
module gni_cfg import gni_pkg::*; #(
    parameter int MAX_SIDE = SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output geom_t                 geom
);

    localparam int SIDE_CAP = (MAX_SIDE < 511) ? MAX_SIDE : 511;

    logic [CNT_W-1:0]            axis_count_reg;
    logic [AXES-1:0][SIZE_W-1:0] size_reg;
    logic [MASK_W-1:0]           periodic_reg;
    logic [SETTLE_W-1:0]         settle_reg;
    logic                        clear_reg;
    logic [AXES-1:0][IDX_W-1:0]  stride_reg;
    logic [AXES-1:0][NB_W-1:0]   wrap_reg;
    logic [AXES-1:0][IDX_W-1:0]  stride_next;
    logic [AXES-1:0][NB_W-1:0]   wrap_next;
    logic [AXES-1:0][SIZE_W-1:0] eff_size;
    logic [AXES-1:0]             used;
    logic [CNT_W-1:0]            n_axes;
    logic                        wr_en;
    logic                        wr_known;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    always_comb begin
        case (cfg_index)
            REG_AXIS_COUNT, REG_SIZE_AXIS0, REG_SIZE_AXIS1,
            REG_SIZE_AXIS2, REG_PERIODIC: wr_known = 1'b1;
            default:                      wr_known = 1'b0;
        endcase
    end

    always_comb begin
        if (axis_count_reg == '0) begin
            n_axes = CNT_W'(1);
        end else if (axis_count_reg > CNT_W'(MAX_AXES)) begin
            n_axes = CNT_W'(MAX_AXES);
        end else begin
            n_axes = axis_count_reg;
        end
        for (int k = 0; k < AXES; k++) begin
            used[k] = CNT_W'(k) < n_axes;
            if (size_reg[k] < SIZE_W'(2)) begin
                eff_size[k] = SIZE_W'(2);
            end else if (size_reg[k] > SIZE_W'(SIDE_CAP)) begin
                eff_size[k] = SIZE_W'(SIDE_CAP);
            end else begin
                eff_size[k] = size_reg[k];
            end
        end
    end

    // strides for row-major order, last used axis has stride 1
    always_comb begin
        stride_next = '0;
        case (n_axes)
            CNT_W'(1): begin
                stride_next[0] = IDX_W'(1);
            end
            CNT_W'(2): begin
                stride_next[0] = IDX_W'(eff_size[1]);
                stride_next[1] = IDX_W'(1);
            end
            default: begin
                stride_next[0] = IDX_W'(eff_size[1]) * IDX_W'(eff_size[2]);
                stride_next[1] = IDX_W'(eff_size[2]);
                stride_next[2] = IDX_W'(1);
            end
        endcase
        for (int k = 0; k < AXES; k++) begin
            wrap_next[k] = NB_W'(stride_reg[k]) * NB_W'(eff_size[k] - SIZE_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        stride_reg <= stride_next;
        wrap_reg   <= wrap_next;
        if (!aresetn) begin
            axis_count_reg <= CNT_W'(3);
            size_reg       <= {AXES{SIZE_W'(2)}};
            periodic_reg   <= '0;
            settle_reg     <= SETTLE_W'(2);
            clear_reg      <= 1'b0;
        end else begin
            clear_reg <= wr_en && wr_known;
            if (wr_en) begin
                settle_reg <= SETTLE_W'(2);
                case (cfg_index)
                    REG_AXIS_COUNT: axis_count_reg <= cfg_data[CNT_W-1:0];
                    REG_SIZE_AXIS0: size_reg[0]    <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_AXIS1: size_reg[1]    <= cfg_data[SIZE_W-1:0];
                    REG_SIZE_AXIS2: size_reg[2]    <= cfg_data[SIZE_W-1:0];
                    REG_PERIODIC:   periodic_reg   <= cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - SETTLE_W'(1);
            end
        end
    end

    assign geom.used     = used;
    assign geom.periodic = periodic_reg;
    assign geom.size     = eff_size;
    assign geom.stride   = stride_reg;
    assign geom.wrap     = wrap_reg;
    assign geom.busy     = (settle_reg != '0) || wr_en;
    assign geom.clear    = clear_reg;

endmodule

/* hw/rtl/gni_walk.sv */
// cell walker: input register, neighbor logic and result register
module gni_walk import gni_pkg::*; #(
    parameter int MAX_SIDE = SIDE_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  geom_t               geom,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast
);

    localparam int SIDE_CAP = (MAX_SIDE < 511) ? MAX_SIDE : 511;
    localparam int CW       = (SIDE_CAP > 2) ? $clog2(SIDE_CAP) : 1;

    logic                        in_valid_reg;
    logic                        in_restart_reg;
    logic                        out_valid_reg;
    logic [M_DATA_W-1:0]         out_data_reg;
    logic                        out_last_reg;
    logic [AXES-1:0][CW-1:0]     coord_reg;
    logic [IDX_W-1:0]            counter_reg;

    logic [AXES-1:0][CW-1:0]     coord_cur;
    logic [AXES-1:0][CW-1:0]     coord_next;
    logic [IDX_W-1:0]            cur_index;
    logic [IDX_W-1:0]            counter_next;
    logic [NB_W-1:0]             cell_ext;
    logic [AXES-1:0][NB_W-1:0]   lo;
    logic [AXES-1:0][NB_W-1:0]   hi;
    logic [AXES-1:0]             at_max;
    logic                        last;
    logic                        carry;
    logic                        fire;
    logic [M_DATA_W-1:0]         data_next;

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !geom.busy && (!in_valid_reg || fire);

    always_comb begin
        coord_cur = in_restart_reg ? '0 : coord_reg;
        cur_index = in_restart_reg ? '0 : counter_reg;
        cell_ext  = NB_W'(cur_index);
        last      = 1'b1;
        for (int k = 0; k < AXES; k++) begin
            at_max[k] = SIZE_W'(coord_cur[k]) >= (geom.size[k] - SIZE_W'(1));
            lo[k] = '1;
            hi[k] = '1;
            if (geom.used[k]) begin
                if (coord_cur[k] == '0) begin
                    lo[k] = geom.periodic[k] ? cell_ext + geom.wrap[k] : '1;
                    hi[k] = cell_ext + NB_W'(geom.stride[k]);
                end else if (at_max[k]) begin
                    lo[k] = cell_ext - NB_W'(geom.stride[k]);
                    hi[k] = geom.periodic[k] ? cell_ext - geom.wrap[k] : '1;
                end else begin
                    lo[k] = cell_ext - NB_W'(geom.stride[k]);
                    hi[k] = cell_ext + NB_W'(geom.stride[k]);
                end
                if (SIZE_W'(coord_cur[k]) != (geom.size[k] - SIZE_W'(1))) begin
                    last = 1'b0;
                end
            end
        end
        data_next = {2'b00, hi[2], lo[2], hi[1], lo[1], hi[0], lo[0], cur_index};
    end

    // advance innermost used axis first
    always_comb begin
        carry = 1'b1;
        for (int k = AXES - 1; k >= 0; k--) begin
            coord_next[k] = coord_cur[k];
            if (geom.used[k] && carry) begin
                if (at_max[k]) begin
                    coord_next[k] = '0;
                end else begin
                    coord_next[k] = coord_cur[k] + 1'b1;
                    carry = 1'b0;
                end
            end
        end
        if (last) begin
            coord_next   = '0;
            counter_next = '0;
        end else begin
            counter_next = cur_index + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            coord_reg     <= '0;
            counter_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg   <= 1'b1;
                in_restart_reg <= s_tdata[0];
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= data_next;
                out_last_reg  <= last;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (geom.clear) begin
                coord_reg   <= '0;
                counter_reg <= '0;
            end else if (fire) begin
                coord_reg   <= coord_next;
                counter_reg <= counter_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/grid_neighbor_index_generator.sv */
// top level of the grid neighbor index generator
// Walks a grid of one to three axes in row-major order and returns one result item per
// input item: the linear index of the current cell and, per axis, the neighbor one step
// down and one step up (-1 at a free boundary or on an unused axis, wrapped at a periodic
// one). Items flow at one per cycle unless the output stalls or the geometry settles,
// through the input register and the result register around the neighbor adders. Input
// is held off during and after a configuration write, and after reset, while strides and
// wrap offsets are rebuilt; a write to a known register restarts the walk at cell 0.
module grid_neighbor_index_generator import gni_pkg::*; #(
    parameter int MAX_SIDE = SIDE_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // restart
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // cell_index, axis0_minus, axis0_plus, axis1_minus, axis1_plus, axis2_minus, axis2_plus
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    geom_t geom;

    gni_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    gni_walk #(
        .MAX_SIDE (MAX_SIDE)
    ) u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .geom     (geom),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // no item taken right after a configuration write
    a_cfg_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready) |=> !s_tready)
        else $error("input item accepted while geometry settles");

    // every grid has at least two cells, so the last one is never cell 0
    a_last_not_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[IDX_W-1:0] != '0))
        else $error("last cell flagged on cell 0");

    // axis 2 reports no neighbors when it is unused
    a_unused_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !geom.used[2]) |-> (m_tdata[173:124] == '1))
        else $error("unused axis carries a neighbor index");

endmodule

/* tb/sv/grid_neighbor_index_generator_test.sv */
// self-checking testbench of the grid neighbor index generator
module grid_neighbor_index_generator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gni_pkg::*;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct packed {
        logic [IDX_W-1:0]           cell_index;
        logic [5:0][NB_W-1:0]       nb;
        logic                       last;
    } cell_result_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   restart;
        bit                     typed;
        cell_result_t           want;
    } plan_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [NB_W-1:0]      NO_CELL      = '1;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;   // restart
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // cell_index, axis0_minus, axis0_plus, axis1_minus, axis1_plus, axis2_minus, axis2_plus
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    grid_neighbor_index_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // grid walker state kept alongside the block
    logic [CNT_W-1:0]  grid_axes;
    logic [SIZE_W-1:0] grid_size [AXES];
    logic [MASK_W-1:0] grid_periodic;
    int                walk_coord [AXES];
    logic [IDX_W-1:0]  walk_cell;
    logic [IDX_W-1:0]  walk_stride [AXES];

    cell_result_t pending_cells [$];
    plan_row_t    plan [$];

    int send_idle  = 0;
    int recv_stall = 0;
    int long_hold  = 0;
    int errors     = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_last     = 0;
    int n_writes   = 0;

    string nb_name [6] = '{"axis0_minus", "axis0_plus", "axis1_minus", "axis1_plus",
                           "axis2_minus", "axis2_plus"};

    function automatic int axes_used();
        int n;
        n = grid_axes;
        if (n < 1) n = 1;
        if (n > MAX_AXES) n = MAX_AXES;
        return n;
    endfunction

    function automatic int side(int k);
        int s;
        s = grid_size[k];
        if (s < 2) s = 2;
        if (s > SIDE_DEF) s = SIDE_DEF;
        return s;
    endfunction

    function automatic void regrid();
        longint run;
        run = 1;
        for (int k = 0; k < AXES; k++) walk_stride[k] = '0;
        for (int k = axes_used() - 1; k >= 0; k--) begin
            walk_stride[k] = run[IDX_W-1:0];
            run = run * side(k);
        end
        for (int k = 0; k < AXES; k++) walk_coord[k] = 0;
        walk_cell = '0;
    endfunction

    function automatic void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_AXIS_COUNT: grid_axes = data[CNT_W-1:0];
            REG_SIZE_AXIS0: grid_size[0] = data;
            REG_SIZE_AXIS1: grid_size[1] = data;
            REG_SIZE_AXIS2: grid_size[2] = data;
            REG_PERIODIC:   grid_periodic = data[MASK_W-1:0];
            default:        return;
        endcase
        regrid();
    endfunction

    function automatic cell_result_t next_cell(logic restart);
        cell_result_t r;
        int n, s, c;
        logic [NB_W-1:0] here, st, wd;
        bit fin, carry;
        n = axes_used();
        fin = 1'b1;
        if (restart) begin
            for (int k = 0; k < AXES; k++) walk_coord[k] = 0;
            walk_cell = '0;
        end
        here = {1'b0, walk_cell};
        r.cell_index = walk_cell;
        for (int k = 0; k < AXES; k++) begin
            r.nb[2*k]   = NO_CELL;
            r.nb[2*k+1] = NO_CELL;
            if (k < n) begin
                s  = side(k);
                c  = walk_coord[k];
                st = {1'b0, walk_stride[k]};
                wd = NB_W'(longint'(walk_stride[k]) * (s - 1));
                if (c == 0) begin
                    r.nb[2*k]   = grid_periodic[k] ? here + wd : NO_CELL;
                    r.nb[2*k+1] = here + st;
                end else if (c >= s - 1) begin
                    r.nb[2*k]   = here - st;
                    r.nb[2*k+1] = grid_periodic[k] ? here - wd : NO_CELL;
                end else begin
                    r.nb[2*k]   = here - st;
                    r.nb[2*k+1] = here + st;
                end
                if (c != s - 1) fin = 1'b0;
            end
        end
        r.last = fin;
        if (fin) begin
            for (int k = 0; k < AXES; k++) walk_coord[k] = 0;
            walk_cell = '0;
        end else begin
            carry = 1'b1;
            for (int k = n - 1; k >= 0; k--) begin
                if (carry) begin
                    walk_coord[k]++;
                    carry = 1'b0;
                    if (walk_coord[k] >= side(k)) begin
                        walk_coord[k] = 0;
                        carry = 1'b1;
                    end
                end
            end
            walk_cell = walk_cell + 1'b1;
        end
        return r;
    endfunction

    function automatic cell_result_t mk_result(int cell_index, int a0m, int a0p, int a1m,
                                               int a1p, int a2m, int a2p, bit last);
        cell_result_t r;
        r.cell_index = cell_index[IDX_W-1:0];
        r.nb[0] = a0m[NB_W-1:0];
        r.nb[1] = a0p[NB_W-1:0];
        r.nb[2] = a1m[NB_W-1:0];
        r.nb[3] = a1p[NB_W-1:0];
        r.nb[4] = a2m[NB_W-1:0];
        r.nb[5] = a2p[NB_W-1:0];
        r.last  = last;
        return r;
    endfunction

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row = '{ROW_CFG, idx, data, 1'b0, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic add_item(logic restart);
        plan_row_t row;
        row = '{ROW_ITEM, '0, '0, restart, 1'b0, '0};
        plan.push_back(row);
    endtask

    task automatic add_check(logic restart, cell_result_t want);
        plan_row_t row;
        row = '{ROW_ITEM, '0, '0, restart, 1'b1, want};
        plan.push_back(row);
    endtask

    task automatic send_item(logic restart, bit typed, cell_result_t want);
        cell_result_t pred;
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(restart);
        do @(posedge aclk); while (!s_tready);
        pred = next_cell(restart);
        pending_cells.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        note_write(idx, data);
        n_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure_grid(int cnt, int s0, int s1, int s2, int per);
        write_reg(REG_AXIS_COUNT, CFG_DATA_W'(cnt));
        write_reg(REG_SIZE_AXIS0, CFG_DATA_W'(s0));
        write_reg(REG_SIZE_AXIS1, CFG_DATA_W'(s1));
        write_reg(REG_SIZE_AXIS2, CFG_DATA_W'(s2));
        write_reg(REG_PERIODIC, CFG_DATA_W'(per));
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_DATA_W'($urandom_range(511)));
    endtask

    function automatic int rand_side();
        if ($urandom_range(99) < 85) return $urandom_range(2, 4);
        return $urandom_range(511);
    endfunction

    function automatic int rand_wide(int value, int shift);
        if ($urandom_range(3) == 0) return value | ($urandom_range(511) << shift);
        return value;
    endfunction

    always @(negedge aclk) begin
        if (long_hold > 0) begin
            m_tready <= 1'b0;
            long_hold = long_hold - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    cell_result_t got, want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.cell_index = m_tdata[IDX_W-1:0];
            for (int j = 0; j < 6; j++) got.nb[j] = m_tdata[IDX_W + NB_W*j +: NB_W];
            got.last = m_tlast;
            n_results++;
            if (got.last) n_last++;
            if (pending_cells.size() == 0) begin
                $error("result item with nothing expected: cell_index %0d", got.cell_index);
                errors++;
            end else begin
                want = pending_cells.pop_front();
                if (got.cell_index !== want.cell_index) begin
                    $error("cell_index: expected %0d, got %0d", want.cell_index,
                           got.cell_index);
                    errors++;
                end
                for (int j = 0; j < 6; j++) begin
                    if (got.nb[j] !== want.nb[j]) begin
                        $error("%s: expected %0d, got %0d", nb_name[j],
                               $signed(want.nb[j]), $signed(got.nb[j]));
                        errors++;
                    end
                end
                if (got.last !== want.last) begin
                    $error("last_cell: expected %0d, got %0d", want.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int mode;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        grid_axes = 2'd3;
        for (int k = 0; k < AXES; k++) grid_size[k] = 9'd2;
        grid_periodic = '0;
        regrid();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset grid 2x2x2, free boundaries
        add_check(1'b0, mk_result(0, -1, 4, -1, 2, -1, 1, 0));
        add_check(1'b0, mk_result(1, -1, 5, -1, 3, 0, -1, 0));
        repeat (5) add_item(1'b0);
        add_check(1'b0, mk_result(7, 3, -1, 5, -1, 6, -1, 1));
        add_check(1'b0, mk_result(0, -1, 4, -1, 2, -1, 1, 0));
        add_item(1'b0);
        add_check(1'b1, mk_result(0, -1, 4, -1, 2, -1, 1, 0));
        // one periodic axis of the largest size
        add_cfg(REG_AXIS_COUNT, 9'd1);
        add_cfg(REG_SIZE_AXIS0, 9'd256);
        add_cfg(REG_PERIODIC, 9'd7);
        add_check(1'b0, mk_result(0, 255, 1, -1, -1, -1, -1, 0));
        add_item(1'b0);
        // size below range, periodic size of two
        add_cfg(REG_SIZE_AXIS0, 9'd0);
        add_check(1'b0, mk_result(0, 1, 1, -1, -1, -1, -1, 0));
        add_check(1'b0, mk_result(1, 0, 0, -1, -1, -1, -1, 1));
        add_item(1'b0);
        // size above range, axis count zero, writes to unused indexes
        add_cfg(REG_SIZE_AXIS0, 9'd511);
        add_cfg(REG_AXIS_COUNT, 9'd0);
        add_cfg(REG_SPARE_LO, 9'd3);
        add_cfg(REG_SPARE_HI, 9'd511);
        add_check(1'b0, mk_result(0, 255, 1, -1, -1, -1, -1, 0));
        // largest grid, all periodic
        add_cfg(REG_AXIS_COUNT, 9'd3);
        add_cfg(REG_SIZE_AXIS1, 9'd256);
        add_cfg(REG_SIZE_AXIS2, 9'd256);
        add_check(1'b0, mk_result(0, 16711680, 65536, 65280, 256, 255, 1, 0));
        add_item(1'b0);
        add_item(1'b0);
        add_cfg(REG_PERIODIC, 9'd0);
        add_cfg(REG_AXIS_COUNT, 9'd2);
        add_check(1'b0, mk_result(0, -1, 256, -1, 1, -1, -1, 0));
        add_item(1'b1);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                send_item(plan[i].restart, plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < 14; p++) begin
            drain();
            mode = p % 4;
            send_idle  = (mode == 1) ? 57 : (mode == 3) ? 33 : 0;
            recv_stall = (mode == 2) ? 57 : (mode == 3) ? 33 : 0;
            case (p)
                0: configure_grid(3, 2, 2, 2, 0);
                1: configure_grid(3, 256, 256, 256, 7);
                2: configure_grid(1, 256, rand_side(), rand_side(), 1);
                3: configure_grid(2, 2, 2, 2, 3);
                default: configure_grid(rand_wide($urandom_range(3), 2), rand_side(),
                                        rand_side(), rand_side(),
                                        rand_wide($urandom_range(7), 3));
            endcase
            if (mode == 0 && p > 0) long_hold = 300;
            for (int i = 0; i < 32; i++) send_item($urandom_range(99) < 4, 1'b0, '0);
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("covered %0d items and %0d results (%0d at the last cell), %0d register writes",
                 n_items, n_results, n_last, n_writes);
        $display("grids from 2 to 256 cells per side, free and periodic, under four idling mixes");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
